// File: rtl/thpg_pkg.sv
`default_nettype none

package thpg_pkg;

  // pattern store geometry
  localparam int PAT_MAX_W     = 64;
  localparam int PAT_MAX_H     = 64;
  localparam int MAX_LAYERS    = 4;
  localparam int MAP_MAX_CELLS = 128;

  // field widths
  localparam int COORD_W  = 12;
  localparam int PIX_W    = 8;
  localparam int HEIGHT_W = 11;
  localparam int CELL_W   = 8;
  localparam int LSUM_W   = 10;

  // scaling divider: remainder stays below the cell count, quotient below ten pattern widths
  localparam int DIVR_W = 7;
  localparam int QUO_W  = 10;
  localparam int NUM_W  = DIVR_W + QUO_W;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_PAT_W  = 3'd0;
  localparam logic [2:0] CFG_PAT_H  = 3'd1;
  localparam logic [2:0] CFG_MAP_W  = 3'd2;
  localparam logic [2:0] CFG_MAP_H  = 3'd3;
  localparam logic [2:0] CFG_LAYERS = 3'd4;

  // partial remainder and quotient shifting in one divider lane
  typedef struct packed {
    logic [DIVR_W-1:0] rem;
    logic [QUO_W-1:0]  acc;
  } div_axis_t;

  // item payload carried down the pipeline
  typedef struct packed {
    logic               req;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   val;
    logic [LSUM_W-1:0]  gsum;
    logic [LSUM_W-1:0]  bsum;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/tiled_heightmap_pixel_generator.sv
// channel  | direction | handshake        | payload
// ---------+-----------+------------------+-------------------------------------------
// in_      | in        | in_valid/in_stall | req_type, coord_x/y, pattern_value, layers
// out_     | out       | out_valid/out_stall | pixel_x/y, ground_height, bush_height
// cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// ten register stages: operand scale, five radix-4 divider stages, split into whole
// and tenths, store read, weighted sum, scale by 1/100 into the output register
// one item per cycle sustained while out_stall is low
// the pattern store is four 1024-entry banks split by row and column parity, one read each
// rst_n clears the valid bits and loads the configuration defaults; data registers and the store are left unwritten
// stalls propagate back stage by stage, so empty stages keep filling while out_stall is high
`default_nettype none

module tiled_heightmap_pixel_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [11:0] in_coord_x,
  input  logic [11:0] in_coord_y,
  input  logic [7:0]  in_pattern_value,
  input  logic [7:0]  in_layer_height_0,
  input  logic [7:0]  in_layer_height_1,
  input  logic [7:0]  in_layer_height_2,
  input  logic [7:0]  in_layer_height_3,
  input  logic [7:0]  in_bush_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_pixel_x,
  output logic [11:0] out_pixel_y,
  output logic [10:0] out_ground_height,
  output logic [10:0] out_bush_height,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int NSTG = 10;

  // configuration, held already clamped
  logic [6:0] pw_r, ph_r;
  logic [7:0] mw_r, mh_r;
  logic [2:0] nl_r;

  logic [6:0] cfg_pw_nxt, cfg_ph_nxt;
  logic [7:0] cfg_mw_nxt, cfg_mh_nxt;
  logic [2:0] cfg_nl_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_pw_nxt = (cfg_data[6:0] == 7'd0) ? 7'd1 :
                 (cfg_data[6:0] > 7'd64) ? 7'd64 : cfg_data[6:0];
    cfg_ph_nxt = cfg_pw_nxt;
    cfg_mw_nxt = (cfg_data == 8'd0) ? 8'd1 : (cfg_data > 8'd128) ? 8'd128 : cfg_data;
    cfg_mh_nxt = cfg_mw_nxt;
    cfg_nl_nxt = (cfg_data[2:0] == 3'd0) ? 3'd1 :
                 (cfg_data[2:0] > 3'd4) ? 3'd4 : cfg_data[2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r <= 7'd64;
      ph_r <= 7'd64;
      mw_r <= 8'd128;
      mh_r <= 8'd128;
      nl_r <= 3'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        thpg_pkg::CFG_PAT_W:  pw_r <= cfg_pw_nxt;
        thpg_pkg::CFG_PAT_H:  ph_r <= cfg_ph_nxt;
        thpg_pkg::CFG_MAP_W:  mw_r <= cfg_mw_nxt;
        thpg_pkg::CFG_MAP_H:  mh_r <= cfg_mh_nxt;
        thpg_pkg::CFG_LAYERS: nl_r <= cfg_nl_nxt;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = !out_stall;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NSTG-1];

  thpg_pkg::item_t item_r [0:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          // loads end at the store stage
          if (k == 8) begin
            vld_r[k] <= vld_r[7] && (item_r[7].req == thpg_pkg::REQ_PIXEL);
          end else begin
            vld_r[k] <= vld_r[k-1];
          end
        end
      end
    end
  end

  // stage 0: clamp to the map, scale by pattern size * 10 / 32
  logic [11:0] lim_x, lim_y, cx, cy;
  logic [18:0] prod_x, prod_y;
  logic [21:0] ten_x, ten_y;
  logic [7:0]  lh [4];
  thpg_pkg::item_t     item0_nxt;
  thpg_pkg::div_axis_t divx0_nxt, divy0_nxt;

  assign lh[0] = in_layer_height_0;
  assign lh[1] = in_layer_height_1;
  assign lh[2] = in_layer_height_2;
  assign lh[3] = in_layer_height_3;

  always_comb begin
    lim_x  = {7'(mw_r - 8'd1), 5'h1f};
    lim_y  = {7'(mh_r - 8'd1), 5'h1f};
    cx     = (in_coord_x > lim_x) ? lim_x : in_coord_x;
    cy     = (in_coord_y > lim_y) ? lim_y : in_coord_y;
    prod_x = 19'(cx) * 19'(pw_r);
    prod_y = 19'(cy) * 19'(ph_r);
    ten_x  = {prod_x, 3'b000} + 22'({prod_x, 1'b0});
    ten_y  = {prod_y, 3'b000} + 22'({prod_y, 1'b0});
    divx0_nxt.rem = ten_x[21:15];
    divx0_nxt.acc = ten_x[14:5];
    divy0_nxt.rem = ten_y[21:15];
    divy0_nxt.acc = ten_y[14:5];

    item0_nxt.req  = in_req_type;
    item0_nxt.x    = in_coord_x;
    item0_nxt.y    = in_coord_y;
    item0_nxt.val  = in_pattern_value;
    item0_nxt.gsum = '0;
    item0_nxt.bsum = '0;
    // layer sums, bush sum stops at the bush start layer
    for (int l = 0; l < 4; l++) begin
      if (3'(l) < nl_r) begin
        item0_nxt.gsum = item0_nxt.gsum + 10'(lh[l]);
        if (8'(l) < in_bush_start) begin
          item0_nxt.bsum = item0_nxt.bsum + 10'(lh[l]);
        end
      end
    end
  end

  // payload shift down the stages
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      item_r[0] <= item0_nxt;
    end
    for (int k = 1; k <= 8; k++) begin
      if (rdy[k]) begin
        item_r[k] <= item_r[k-1];
      end
    end
  end

  // stages 1 to 5: divide by the cell count, two quotient bits a stage
  thpg_pkg::div_axis_t divx_r [0:5];
  thpg_pkg::div_axis_t divy_r [0:5];
  thpg_pkg::div_axis_t x_mid [1:5], x_nxt [1:5];
  thpg_pkg::div_axis_t y_mid [1:5], y_nxt [1:5];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      divx_r[0] <= divx0_nxt;
      divy_r[0] <= divy0_nxt;
    end
  end

  for (genvar g = 1; g <= 5; g++) begin : g_div
    thpg_div_step u_x_hi (.step_in(divx_r[g-1]), .divisor(mw_r), .step_out(x_mid[g]));
    thpg_div_step u_x_lo (.step_in(x_mid[g]),    .divisor(mw_r), .step_out(x_nxt[g]));
    thpg_div_step u_y_hi (.step_in(divy_r[g-1]), .divisor(mh_r), .step_out(y_mid[g]));
    thpg_div_step u_y_lo (.step_in(y_mid[g]),    .divisor(mh_r), .step_out(y_nxt[g]));

    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        divx_r[g] <= x_nxt[g];
        divy_r[g] <= y_nxt[g];
      end
    end
  end

  // stage 6: whole pixel and tenths, edge fallback by zeroing the fraction
  logic [17:0] xs_mul, ys_mul;
  logic [5:0]  xs_nxt, ys_nxt;
  logic [9:0]  xr_full, yr_full;
  logic [3:0]  xr_nxt, yr_nxt;
  logic [5:0]  s_xs_r, s_ys_r;
  logic [3:0]  s_xr_r, s_yr_r;

  always_comb begin
    xs_mul  = 18'(divx_r[5].acc) * 18'd205;
    ys_mul  = 18'(divy_r[5].acc) * 18'd205;
    xs_nxt  = xs_mul[16:11];
    ys_nxt  = ys_mul[16:11];
    xr_full = divx_r[5].acc - {1'b0, xs_nxt, 3'b000} - {3'b000, xs_nxt, 1'b0};
    yr_full = divy_r[5].acc - {1'b0, ys_nxt, 3'b000} - {3'b000, ys_nxt, 1'b0};
    xr_nxt  = (xs_nxt == 6'(pw_r - 7'd1)) ? 4'd0 : xr_full[3:0];
    yr_nxt  = (ys_nxt == 6'(ph_r - 7'd1)) ? 4'd0 : yr_full[3:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s_xs_r <= xs_nxt;
      s_ys_r <= ys_nxt;
      s_xr_r <= xr_nxt;
      s_yr_r <= yr_nxt;
    end
  end

  // stage 7: parity banks, each neighbour lands in a different bank
  logic [9:0] raddr [4];
  logic [7:0] rd_r  [4];
  logic       wen;
  logic [1:0] wbank;
  logic [9:0] waddr;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      raddr[b] = {(s_ys_r[0] == b[1]) ? s_ys_r[5:1] : 5'(({1'b0, s_ys_r} + 7'd1) >> 1),
                  (s_xs_r[0] == b[0]) ? s_xs_r[5:1] : 5'(({1'b0, s_xs_r} + 7'd1) >> 1)};
    end
    wen   = rdy[7] && vld_r[6] && (item_r[6].req == thpg_pkg::REQ_LOAD) &&
            (item_r[6].x[11:6] == 6'd0) && (item_r[6].y[11:6] == 6'd0);
    wbank = {item_r[6].y[0], item_r[6].x[0]};
    waddr = {item_r[6].y[5:1], item_r[6].x[5:1]};
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0] mem [1024];

    always_ff @(posedge clk) begin
      if (wen && (wbank == 2'(b))) begin
        mem[waddr] <= item_r[6].val;
      end
      if (rdy[7]) begin
        rd_r[b] <= mem[raddr[b]];
      end
    end
  end

  // bilinear weights, worked out alongside the store read
  logic       r_xs0_r, r_ys0_r, r_xf_r, r_yf_r;
  logic [6:0] w00_r, w10_r, w01_r, w11_r;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      r_xs0_r <= s_xs_r[0];
      r_ys0_r <= s_ys_r[0];
      r_xf_r  <= (s_xr_r != 4'd0);
      r_yf_r  <= (s_yr_r != 4'd0);
      w00_r   <= 7'(4'(4'd10 - s_xr_r) * 4'(4'd10 - s_yr_r));
      w10_r   <= 7'(s_xr_r * 4'(4'd10 - s_yr_r));
      w01_r   <= 7'(4'(4'd10 - s_xr_r) * s_yr_r);
      w11_r   <= 7'(s_xr_r * s_yr_r);
    end
  end

  // stage 8: weighted sum of the four neighbours
  logic [7:0]  p00, p10, p01, p11;
  logic [14:0] sum_nxt, m_sum_r;

  always_comb begin
    p00 = rd_r[{r_ys0_r, r_xs0_r}];
    p10 = r_xf_r ? rd_r[{r_ys0_r, !r_xs0_r}] : 8'd0;
    p01 = r_yf_r ? rd_r[{!r_ys0_r, r_xs0_r}] : 8'd0;
    p11 = (r_xf_r && r_yf_r) ? rd_r[{!r_ys0_r, !r_xs0_r}] : 8'd0;
    sum_nxt = 15'(w00_r) * 15'(p00) + 15'(w10_r) * 15'(p10) +
              15'(w01_r) * 15'(p01) + 15'(w11_r) * 15'(p11);
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      m_sum_r <= sum_nxt;
    end
  end

  // stage 9: divide by 100 through the reciprocal, add the layers
  logic [27:0] h_mul;
  logic [7:0]  h_nxt;
  logic [11:0] o_x_r, o_y_r;
  logic [10:0] o_ground_r, o_bush_r;

  always_comb begin
    h_mul = 28'(m_sum_r) * 28'd5243;
    h_nxt = h_mul[26:19];
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      o_x_r      <= item_r[8].x;
      o_y_r      <= item_r[8].y;
      o_ground_r <= 11'(h_nxt) + 11'(item_r[8].gsum);
      o_bush_r   <= 11'(h_nxt) + 11'(item_r[8].bsum);
    end
  end

  assign out_pixel_x       = o_x_r;
  assign out_pixel_y       = o_y_r;
  assign out_ground_height = o_ground_r;
  assign out_bush_height   = o_bush_r;

`ifndef SYNTHESIS
  a_no_load_past_store: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[8] |-> item_r[8].req == thpg_pkg::REQ_PIXEL)
    else $error("load item passed the store stage");

  a_bush_le_ground: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bush_height <= out_ground_height)
    else $error("bush height above ground height");

  a_fraction_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[6] |-> (s_xr_r <= 4'd9) && (s_yr_r <= 4'd9))
    else $error("tenths out of range");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r) && out_stall)
    else $error("input stalled with a bubble in the pipeline");
`endif

endmodule

`default_nettype wire

// File: rtl/thpg_div_step.sv
`default_nettype none

module thpg_div_step (
  input  thpg_pkg::div_axis_t step_in,
  input  logic [7:0]          divisor,
  output thpg_pkg::div_axis_t step_out
);

  logic [7:0] trial;
  logic       take;

  // one restoring step: bring down the next numerator bit, subtract if it fits
  always_comb begin
    trial         = {step_in.rem, step_in.acc[thpg_pkg::QUO_W-1]};
    take          = (trial >= divisor);
    step_out.rem  = take ? 7'(trial - divisor) : trial[6:0];
    step_out.acc  = {step_in.acc[thpg_pkg::QUO_W-2:0], take};
  end

endmodule

`default_nettype wire

// File: tb/sv/tiled_heightmap_pixel_generator_tb.sv
`default_nettype none

module tiled_heightmap_pixel_generator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int FILL_SIDE = 16;

  typedef struct {
    logic        req;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  val;
    logic [7:0]  lh [4];
    logic [7:0]  bs;
  } map_item_t;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic [10:0] ground;
    logic [10:0] bush;
  } height_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [11:0] in_coord_x;
  logic [11:0] in_coord_y;
  logic [7:0]  in_pattern_value;
  logic [7:0]  in_layer_height_0;
  logic [7:0]  in_layer_height_1;
  logic [7:0]  in_layer_height_2;
  logic [7:0]  in_layer_height_3;
  logic [7:0]  in_bush_start;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] out_pixel_x;
  logic [11:0] out_pixel_y;
  logic [10:0] out_ground_height;
  logic [10:0] out_bush_height;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  map_item_t   pending_items[$];
  height_res_t expected_heights[$];
  logic [7:0]  pattern_mirror [thpg_pkg::PAT_MAX_W*thpg_pkg::PAT_MAX_H];

  // shadow registers
  int unsigned sh_pat_w, sh_pat_h, sh_map_w, sh_map_h, sh_layers;

  int  mismatches;
  int  quiet_cycles;
  bit  steady;
  bit  in_taken;

  tiled_heightmap_pixel_generator i_dut (.*);

  // clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned pattern_at(int unsigned col, int unsigned row);
    int unsigned a;
    a = row * thpg_pkg::PAT_MAX_W + col;
    return (a < thpg_pkg::PAT_MAX_W*thpg_pkg::PAT_MAX_H) ? pattern_mirror[a] : 0;
  endfunction

  // map coordinate into pattern space, in tenths
  function automatic int unsigned coord_tenths(int unsigned coord, int unsigned cells,
                                               int unsigned psize);
    int unsigned mapsz, c;
    mapsz = cells * 32;
    c = (coord >= mapsz) ? mapsz - 1 : coord;
    return c * psize * 10 / mapsz;
  endfunction

  function automatic height_res_t sample_heights(map_item_t it);
    height_res_t r;
    int unsigned pw, ph, mw, mh, nl, xc, yc, xs, xr, ys, yr, h, g, b;
    bit last_row, last_col;
    pw = clamp_u(sh_pat_w, 1, thpg_pkg::PAT_MAX_W);
    ph = clamp_u(sh_pat_h, 1, thpg_pkg::PAT_MAX_H);
    mw = clamp_u(sh_map_w, 1, thpg_pkg::MAP_MAX_CELLS);
    mh = clamp_u(sh_map_h, 1, thpg_pkg::MAP_MAX_CELLS);
    nl = clamp_u(sh_layers, 1, thpg_pkg::MAX_LAYERS);
    if (nl > 4) nl = 4;
    xc = coord_tenths(it.x, mw, pw);
    yc = coord_tenths(it.y, mh, ph);
    xs = xc / 10;
    xr = xc % 10;
    ys = yc / 10;
    yr = yc % 10;
    last_row = (ys == ph - 1);
    last_col = (xs == pw - 1);
    // bilinear, falling back to linear then nearest at the far edges
    if (!last_row && !last_col) begin
      h = ((10 - xr) * (10 - yr) * pattern_at(xs, ys) + xr * (10 - yr) * pattern_at(xs + 1, ys)
           + (10 - xr) * yr * pattern_at(xs, ys + 1) + xr * yr * pattern_at(xs + 1, ys + 1))
          / 100;
    end else if (!last_row) begin
      h = ((10 - yr) * pattern_at(xs, ys) + yr * pattern_at(xs, ys + 1)) / 10;
    end else if (!last_col) begin
      h = ((10 - xr) * pattern_at(xs, ys) + xr * pattern_at(xs + 1, ys)) / 10;
    end else begin
      h = pattern_at(xs, ys);
    end
    g = h;
    b = h;
    for (int unsigned l = 0; l < nl; l++) begin
      g += it.lh[l];
      if (l < it.bs) b += it.lh[l];
    end
    r.x = it.x;
    r.y = it.y;
    r.ground = g[10:0];
    r.bush = b[10:0];
    return r;
  endfunction

  // accepted input items and config writes
  always @(posedge clk) begin
    map_item_t it;
    in_taken <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      it.req = in_req_type;
      it.x = in_coord_x;
      it.y = in_coord_y;
      it.val = in_pattern_value;
      it.lh[0] = in_layer_height_0;
      it.lh[1] = in_layer_height_1;
      it.lh[2] = in_layer_height_2;
      it.lh[3] = in_layer_height_3;
      it.bs = in_bush_start;
      if (it.req == thpg_pkg::REQ_PIXEL) begin
        expected_heights.push_back(sample_heights(it));
      end else if (it.x < thpg_pkg::PAT_MAX_W && it.y < thpg_pkg::PAT_MAX_H) begin
        pattern_mirror[it.y * thpg_pkg::PAT_MAX_W + it.x] = it.val;
      end
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        thpg_pkg::CFG_PAT_W:  sh_pat_w = cfg_data & 8'h7f;
        thpg_pkg::CFG_PAT_H:  sh_pat_h = cfg_data & 8'h7f;
        thpg_pkg::CFG_MAP_W:  sh_map_w = cfg_data;
        thpg_pkg::CFG_MAP_H:  sh_map_h = cfg_data;
        thpg_pkg::CFG_LAYERS: sh_layers = cfg_data & 8'h07;
        default: ;
      endcase
    end
  end

  // driver: next item presented at the falling edge
  always @(negedge clk) begin
    map_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() > 0 && (steady || $urandom_range(99) >= 15)) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        in_req_type <= it.req;
        in_coord_x <= it.x;
        in_coord_y <= it.y;
        in_pattern_value <= it.val;
        in_layer_height_0 <= it.lh[0];
        in_layer_height_1 <= it.lh[1];
        in_layer_height_2 <= it.lh[2];
        in_layer_height_3 <= it.lh[3];
        in_bush_start <= it.bs;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !steady && ($urandom_range(99) < 15);
  end

  // monitor
  always @(posedge clk) begin
    height_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_heights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x=%0d y=%0d", out_pixel_x, out_pixel_y);
      end else begin
        e = expected_heights.pop_front();
        if (out_pixel_x !== e.x || out_pixel_y !== e.y ||
            out_ground_height !== e.ground || out_bush_height !== e.bush) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%0d y=%0d g=%0d b=%0d  got x=%0d y=%0d g=%0d b=%0d",
                     e.x, e.y, e.ground, e.bush, out_pixel_x, out_pixel_y,
                     out_ground_height, out_bush_height);
        end
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tiled_heightmap_pixel_generator test failed");
      $finish;
    end
  end

  task automatic add_load(int unsigned x, int unsigned y, int unsigned v);
    map_item_t it;
    it.req = thpg_pkg::REQ_LOAD;
    it.x = x;
    it.y = y;
    it.val = v;
    for (int l = 0; l < 4; l++) it.lh[l] = $urandom;
    it.bs = $urandom;
    pending_items.push_back(it);
  endtask

  task automatic add_pixel(int unsigned x, int unsigned y, int unsigned h0, int unsigned h1,
                           int unsigned h2, int unsigned h3, int unsigned bs);
    map_item_t it;
    it.req = thpg_pkg::REQ_PIXEL;
    it.x = x;
    it.y = y;
    it.val = $urandom;
    it.lh[0] = h0;
    it.lh[1] = h1;
    it.lh[2] = h2;
    it.lh[3] = h3;
    it.bs = bs;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for the pipeline to empty, loads included
  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid && expected_heights.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(int unsigned pw, int unsigned ph, int unsigned mw,
                            int unsigned mh, int unsigned nl);
    write_reg(thpg_pkg::CFG_PAT_W, 8'(pw));
    write_reg(thpg_pkg::CFG_PAT_H, 8'(ph));
    write_reg(thpg_pkg::CFG_MAP_W, 8'(mw));
    write_reg(thpg_pkg::CFG_MAP_H, 8'(mh));
    write_reg(thpg_pkg::CFG_LAYERS, 8'(nl));
  endtask

  task automatic add_random(int n);
    int unsigned mw, mh, x, y;
    mw = clamp_u(sh_map_w, 1, thpg_pkg::MAP_MAX_CELLS) * 32;
    mh = clamp_u(sh_map_h, 1, thpg_pkg::MAP_MAX_CELLS) * 32;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) begin
        // loads, some outside the store
        if ($urandom_range(3) == 0) add_load($urandom_range(4095), $urandom_range(4095), $urandom);
        else add_load($urandom_range(63), $urandom_range(63), $urandom);
      end else begin
        if ($urandom_range(4) == 0) begin
          x = $urandom_range(4095);
          y = $urandom_range(4095);
        end else begin
          x = $urandom_range(mw - 1);
          y = $urandom_range(mh - 1);
        end
        add_pixel(x, y, $urandom, $urandom, $urandom, $urandom,
                  ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(5));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = thpg_pkg::REQ_LOAD;
    in_coord_x = '0;
    in_coord_y = '0;
    in_pattern_value = '0;
    in_layer_height_0 = '0;
    in_layer_height_1 = '0;
    in_layer_height_2 = '0;
    in_layer_height_3 = '0;
    in_bush_start = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = thpg_pkg::CFG_PAT_W;
    cfg_data = '0;
    mismatches = 0;
    quiet_cycles = 0;
    steady = 1'b0;
    in_taken = 1'b0;
    sh_pat_w = 64;
    sh_pat_h = 64;
    sh_map_w = 128;
    sh_map_h = 128;
    sh_layers = 3;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill the corner block plus the whole first row and column;
    // every pattern size used below stays inside the filled part
    for (int r = 0; r < FILL_SIDE; r++)
      for (int c = 0; c < FILL_SIDE; c++)
        add_load(c, r, (r == 0 && c == 0) ? 255 : $urandom);
    for (int c = FILL_SIDE; c < thpg_pkg::PAT_MAX_W; c++)
      add_load(c, 0, $urandom);
    for (int r = FILL_SIDE; r < thpg_pkg::PAT_MAX_H; r++)
      add_load(0, r, $urandom);
    add_load(thpg_pkg::PAT_MAX_W, 0, 8'haa);
    add_load(4095, 4095, 8'h55);
    drain();

    // directed: extremes
    set_config(FILL_SIDE, FILL_SIDE, 128, 128, 3);
    add_pixel(0, 0, 0, 0, 0, 0, 0);
    add_pixel(4095, 4095, 255, 255, 255, 255, 255);
    add_pixel(4095, 0, 255, 255, 255, 255, 1);
    add_pixel(0, 4095, 255, 0, 255, 0, 3);
    add_pixel(4094, 4094, 1, 2, 4, 8, 2);
    add_pixel(2048, 2048, 128, 64, 32, 16, 128);
    add_pixel(100, 4000, 200, 100, 50, 25, 4);
    add_pixel(3000, 17, 7, 7, 7, 7, 0);
    drain();

    // full layer count, long run with no idling
    set_config(FILL_SIDE, FILL_SIDE, 128, 128, 4);
    add_pixel(4095, 4095, 255, 255, 255, 255, 255);
    add_pixel(0, 0, 255, 255, 255, 255, 2);
    steady = 1'b1;
    add_random(100);
    drain();
    steady = 1'b0;

    // minimum sizes: nearest-pixel path everywhere
    set_config(1, 1, 1, 1, 1);
    add_pixel(0, 0, 255, 255, 255, 255, 0);
    add_pixel(31, 31, 255, 0, 0, 0, 1);
    add_pixel(4095, 4095, 9, 9, 9, 9, 255);
    add_random(60);
    drain();

    // out-of-range values saturate
    set_config(127, 0, 255, 0, 0);
    add_random(60);
    drain();
    set_config(8'hff, 8'h80, 8'h81, 8'hfe, 7);
    add_random(60);
    drain();

    // odd sizes, last row and column paths
    set_config(7, 13, 5, 9, 2);
    add_random(80);
    drain();
    set_config(1, 64, 1, 128, 3);
    add_random(80);
    drain();

    if (mismatches == 0) begin
      $display("tiled_heightmap_pixel_generator test passed");
    end else begin
      $display("tiled_heightmap_pixel_generator test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
